// File: rtl/sh128_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh128_pkg
// Shared types, constants and round functions for the 128-bit spooky hash
// stream block.
// ----------------------------------------------------------------------------
package sh128_pkg;

  // message length counter width
  localparam int LEN_BITS    = 32;
  // queue between front and back, depth must be a power of two
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [63:0] PAD_CONST   = 64'hdeadbeefdeadbeef;
  localparam int          SHORT_LIMIT = 192;

  // configuration register indexes
  localparam logic CFG_SEED_LOW  = 1'b0;
  localparam logic CFG_SEED_HIGH = 1'b1;

  // rotation tables
  localparam logic [5:0] MIX_ROT  [12] = '{6'd11, 6'd32, 6'd43, 6'd31, 6'd17, 6'd28,
                                           6'd39, 6'd57, 6'd55, 6'd54, 6'd22, 6'd46};
  localparam logic [5:0] END_ROT  [12] = '{6'd44, 6'd15, 6'd34, 6'd21, 6'd38, 6'd33,
                                           6'd10, 6'd13, 6'd38, 6'd53, 6'd42, 6'd54};
  localparam logic [5:0] SMIX_ROT [12] = '{6'd50, 6'd52, 6'd30, 6'd41, 6'd54, 6'd48,
                                           6'd38, 6'd37, 6'd62, 6'd34, 6'd5,  6'd36};
  localparam logic [5:0] SEND_ROT [11] = '{6'd15, 6'd52, 6'd26, 6'd51, 6'd28, 6'd9,
                                           6'd47, 6'd54, 6'd32, 6'd25, 6'd63};

  typedef logic [63:0]       word_t;
  typedef logic [11:0][63:0] lstate_t;
  typedef logic [3:0][63:0]  sstate_t;

  // one classified word on its way from front to back
  typedef struct packed {
    word_t      data;
    logic [3:0] nb;
    logic [3:0] pos;
    logic       first;
    logic       last;
    logic       block_done;
    logic       is_short;
    logic [7:0] len_lo;
  } item_t;

  typedef enum logic [2:0] {
    BK_RUN,
    BK_SMIX,
    BK_FIN,
    BK_SEND,
    BK_LEND
  } bk_state_t;

  typedef struct packed {
    logic finishing;
    logic smixing;
  } bk_status_t;

  function automatic word_t rotl64(word_t x, logic [5:0] k);
    logic [127:0] t;
    t = {x, x} << k;
    return t[127:64];
  endfunction

  // (i + k) mod 12 for i and k below 12
  function automatic logic [3:0] wrap12(logic [3:0] i, logic [3:0] k);
    logic [4:0] s;
    s = {1'b0, i} + {1'b0, k};
    if (s >= 5'd12) s = s - 5'd12;
    return s[3:0];
  endfunction

  // one row of the long block mix
  function automatic lstate_t long_row(lstate_t s, word_t d, logic [3:0] i);
    logic [3:0] n1, n2, n10, n11;
    n1  = wrap12(i, 4'd1);
    n2  = wrap12(i, 4'd2);
    n10 = wrap12(i, 4'd10);
    n11 = wrap12(i, 4'd11);
    s[i]   = s[i] + d;
    s[n2]  = s[n2] ^ s[n10];
    s[n11] = s[n11] ^ s[i];
    s[i]   = rotl64(s[i], MIX_ROT[i]);
    s[n11] = s[n11] + s[n1];
    return s;
  endfunction

  // one step of the long end round
  function automatic lstate_t end_step(lstate_t h, logic [3:0] i);
    logic [3:0] n1, n2, n11;
    n1  = wrap12(i, 4'd1);
    n2  = wrap12(i, 4'd2);
    n11 = wrap12(i, 4'd11);
    h[n11] = h[n11] + h[n1];
    h[n2]  = h[n2] ^ h[n11];
    h[n1]  = rotl64(h[n1], END_ROT[i]);
    return h;
  endfunction

  // one step of the short mix
  function automatic sstate_t smix_step(sstate_t h, logic [3:0] j);
    logic [1:0] x, y, z;
    x = j[1:0] + 2'd2;
    y = j[1:0] + 2'd3;
    z = j[1:0];
    h[x] = rotl64(h[x], SMIX_ROT[j]);
    h[x] = h[x] + h[y];
    h[z] = h[z] ^ h[x];
    return h;
  endfunction

  // one step of the short end, steps zero to ten
  function automatic sstate_t send_step(sstate_t h, logic [3:0] j);
    logic [1:0] x, z;
    x = j[1:0] + 2'd2;
    z = j[1:0] + 2'd3;
    h[z] = h[z] ^ h[x];
    h[x] = rotl64(h[x], SEND_ROT[j]);
    h[z] = h[z] + h[x];
    return h;
  endfunction

endpackage

// File: rtl/spooky_hash128_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spooky_hash128_stream
// Seeded 128-bit spooky hash over a stream of little-endian 64-bit words.
// ----------------------------------------------------------------------------
// Body words are taken at one per cycle while the back unit is in its run
// state: each word runs one row of the long block mix in the back unit. The
// second word of every 32-byte group starts a short-path mix, during which the
// back unit takes no new word. A four-entry queue lets the input keep flowing
// meanwhile. The last word adds a finish: a load step, then the short end
// (short path, under 192 bytes) or three long end rounds at four steps a cycle;
// the result beat waits in an output register while the next message already
// enters. Seeds are sampled on the first word.
// ----------------------------------------------------------------------------
module spooky_hash128_stream
  import sh128_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_low,
  output logic [63:0] out_hash_high,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  word_t             seed_low_r, seed_low_nxt, seed_high_r, seed_high_nxt;
  logic              q_push, q_pop, q_empty, q_full;
  item_t             q_in, q_head;
  logic [QCNT_W-1:0] q_count;
  bk_status_t        bk_sts;

  // seed registers
  always_comb begin
    seed_low_nxt  = seed_low_r;
    seed_high_nxt = seed_high_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SEED_LOW:  seed_low_nxt  = cfg_data;
        CFG_SEED_HIGH: seed_high_nxt = cfg_data;
        default:       seed_low_nxt  = seed_low_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_low_r  <= '0;
      seed_high_r <= '0;
    end else begin
      seed_low_r  <= seed_low_nxt;
      seed_high_r <= seed_high_nxt;
    end
  end

  sh128_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last_word  (in_last_word),
    .q_full        (q_full),
    .push          (q_push),
    .push_item     (q_in)
  );

  sh128_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full),
    .count     (q_count)
  );

  sh128_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .head          (q_head),
    .pop           (q_pop),
    .seed_low      (seed_low_r),
    .seed_high     (seed_high_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hash_low  (out_hash_low),
    .out_hash_high (out_hash_high),
    .sts           (bk_sts)
  );

  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCNT_W'(QDEPTH))
    else $error("queue fill level above depth");

  // no word leaves the queue while the short mix is running
  a_no_pop_in_mix: assert property (@(posedge clk) disable iff (!rst_n)
    bk_sts.smixing |-> !q_pop)
    else $error("queue popped during short mix");

  // a new result beat only comes out of a finishing pass
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(bk_sts.finishing))
    else $error("result beat without finish");

endmodule

// File: rtl/sh128_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh128_front
// Accepts message words, masks the tail, tracks block position and the
// saturating byte count, and pushes classified items into the queue.
// ----------------------------------------------------------------------------
module sh128_front
  import sh128_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [63:0] in_data_word,
  input  logic [3:0] in_byte_count,
  input  logic       in_last_word,
  input  logic       q_full,
  output logic       push,
  output item_t      push_item
);

  logic [LEN_BITS-1:0] count_r, count_nxt;
  logic [3:0]          pos_r, pos_nxt;
  logic [3:0]          nb;
  logic [LEN_BITS:0]   sum;
  logic [LEN_BITS-1:0] newlen;
  word_t               masked;
  logic                bd;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // byte count and tail mask
  always_comb begin
    if (!in_last_word || in_byte_count > 4'd8) nb = 4'd8;
    else nb = in_byte_count;
    for (int b = 0; b < 8; b++) begin
      masked[b*8 +: 8] = (4'(b) < nb) ? in_data_word[b*8 +: 8] : 8'h00;
    end
  end

  // saturating length
  always_comb begin
    sum    = {1'b0, count_r} + (LEN_BITS + 1)'(nb);
    newlen = sum[LEN_BITS] ? '1 : sum[LEN_BITS-1:0];
    bd     = (pos_r == 4'd11) && (nb == 4'd8);
  end

  always_comb begin
    push_item.data       = masked;
    push_item.nb         = nb;
    push_item.pos        = pos_r;
    push_item.first      = (count_r == '0);
    push_item.last       = in_last_word;
    push_item.block_done = bd;
    push_item.is_short   = newlen < LEN_BITS'(SHORT_LIMIT);
    push_item.len_lo     = newlen[7:0];
  end

  // position and count for the next beat
  always_comb begin
    count_nxt = count_r;
    pos_nxt   = pos_r;
    if (push) begin
      if (in_last_word) begin
        count_nxt = '0;
        pos_nxt   = 4'd0;
      end else begin
        count_nxt = newlen;
        pos_nxt   = bd ? 4'd0 : pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pos_r   <= 4'd0;
    end else begin
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

// File: rtl/sh128_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh128_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module sh128_queue
  import sh128_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  item_t             push_item,
  input  logic              pop,
  output item_t             head,
  output logic              empty,
  output logic              full,
  output logic [QCNT_W-1:0] count
);

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign count = cnt_r;
  assign head  = mem_r[rd_r];

  // pointers and fill level
  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/sh128_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh128_back
// Runs one long mix row per word, the short path updates and short mix,
// then the short or long finish, and holds the result beat.
// ----------------------------------------------------------------------------
module sh128_back
  import sh128_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  item_t       head,
  output logic        pop,
  input  word_t       seed_low,
  input  word_t       seed_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_low,
  output logic [63:0] out_hash_high,
  output bk_status_t  sts
);

  bk_state_t  st_r, st_nxt;
  logic [1:0] grp_r, grp_nxt;
  logic [1:0] rnd_r, rnd_nxt;
  sstate_t    short_r, short_nxt;
  lstate_t    work_r, work_nxt;
  lstate_t    base_r, base_nxt;
  lstate_t    bw_r, bw_nxt;
  lstate_t    h_r, h_nxt;
  word_t      prev_r, prev_nxt;
  word_t      pw_r, pw_nxt;
  item_t      cur_r, cur_nxt;
  logic       ov_r, ov_nxt;
  word_t      oh_lo_r, oh_lo_nxt, oh_hi_r, oh_hi_nxt;

  lstate_t    seed_l;
  sstate_t    seed_s;
  sstate_t    s_tmp;
  lstate_t    l_tmp;
  word_t      buf_w;
  logic [1:0] q;
  logic [5:0] r6;
  logic [4:0] r5;
  logic [7:0] rem;
  logic       out_free;

  assign out_valid     = ov_r;
  assign out_hash_low  = oh_lo_r;
  assign out_hash_high = oh_hi_r;
  assign pop           = (st_r == BK_RUN) && !q_empty;
  assign out_free      = !ov_r || !out_stall;
  assign sts.finishing = (st_r == BK_SEND) || (st_r == BK_LEND);
  assign sts.smixing   = (st_r == BK_SMIX);

  // seeded starting states
  always_comb begin
    for (int i = 0; i < 12; i += 3) begin
      seed_l[i]     = seed_low;
      seed_l[i + 1] = seed_high;
      seed_l[i + 2] = PAD_CONST;
    end
    seed_s = {PAD_CONST, PAD_CONST, seed_high, seed_low};
  end

  // sequencer and datapath
  always_comb begin
    st_nxt    = st_r;
    grp_nxt   = grp_r;
    rnd_nxt   = rnd_r;
    short_nxt = short_r;
    work_nxt  = work_r;
    base_nxt  = base_r;
    bw_nxt    = bw_r;
    h_nxt     = h_r;
    prev_nxt  = prev_r;
    pw_nxt    = pw_r;
    cur_nxt   = cur_r;
    oh_lo_nxt = oh_lo_r;
    oh_hi_nxt = oh_hi_r;
    ov_nxt    = ov_r && out_stall;
    s_tmp     = short_r;
    l_tmp     = h_r;
    buf_w     = '0;
    q         = cur_r.pos[1:0];
    r6        = '0;
    r5        = '0;
    rem       = '0;

    case (st_r)
      BK_RUN: begin
        if (pop) begin
          q     = head.pos[1:0];
          s_tmp = head.first ? seed_s : short_r;
          case (q)
            2'd0: s_tmp[2] = s_tmp[2] + head.data;
            2'd1: s_tmp[3] = s_tmp[3] + head.data;
            2'd3: begin
              if (head.nb == 4'd8) begin
                s_tmp[0] = s_tmp[0] + prev_r;
                s_tmp[1] = s_tmp[1] + head.data;
              end
            end
            default: s_tmp = s_tmp;
          endcase
          short_nxt = s_tmp;
          work_nxt  = long_row(head.first ? seed_l : work_r, head.data, head.pos);
          if (head.block_done) base_nxt = work_nxt;
          else if (head.first) base_nxt = seed_l;
          bw_nxt[head.pos] = head.data;
          prev_nxt = head.data;
          pw_nxt   = prev_r;
          cur_nxt  = head;
          grp_nxt  = 2'd0;
          if (q == 2'd1 && head.nb == 4'd8) st_nxt = BK_SMIX;
          else if (head.last) st_nxt = BK_FIN;
        end
      end

      // four short mix steps a cycle
      BK_SMIX: begin
        for (int k = 0; k < 4; k++) begin
          s_tmp = smix_step(s_tmp, {grp_r, 2'(k)});
        end
        short_nxt = s_tmp;
        grp_nxt   = grp_r + 2'd1;
        if (grp_r == 2'd2) begin
          grp_nxt = 2'd0;
          st_nxt  = cur_r.last ? BK_FIN : BK_RUN;
        end
      end

      // load the finishing state
      BK_FIN: begin
        grp_nxt = 2'd0;
        rnd_nxt = 2'd0;
        if (cur_r.is_short) begin
          s_tmp = short_r;
          if (q == 2'd2) begin
            s_tmp[2] = s_tmp[2] + cur_r.data;
          end else if (q == 2'd3 && cur_r.nb != 4'd8) begin
            s_tmp[2] = s_tmp[2] + pw_r;
            s_tmp[3] = s_tmp[3] + cur_r.data;
          end
          r6 = {1'b0, q, 3'b000} + {2'b00, cur_r.nb};
          r5 = r6[4:0];
          if (r5 >= 5'd16) r5 = r5 - 5'd16;
          if (r5 == 5'd0) begin
            s_tmp[2] = s_tmp[2] + PAD_CONST;
            s_tmp[3] = s_tmp[3] + PAD_CONST;
          end
          s_tmp[3] = s_tmp[3] + {cur_r.len_lo, 56'd0};
          h_nxt        = '0;
          h_nxt[3:0]   = s_tmp;
          st_nxt       = BK_SEND;
        end else begin
          if (!cur_r.block_done) rem = {1'b0, cur_r.pos, 3'b000} + {4'd0, cur_r.nb};
          for (int i = 0; i < 12; i++) begin
            buf_w = (!cur_r.block_done && 4'(i) <= cur_r.pos) ? bw_r[i] : 64'd0;
            if (i == 11) buf_w = buf_w | {rem, 56'd0};
            h_nxt[i] = base_r[i] + buf_w;
          end
          st_nxt = BK_LEND;
        end
      end

      // short end, eleven steps
      BK_SEND: begin
        s_tmp = h_r[3:0];
        for (int k = 0; k < 4; k++) begin
          if ({grp_r, 2'(k)} != 4'd11) s_tmp = send_step(s_tmp, {grp_r, 2'(k)});
        end
        if (grp_r != 2'd2) begin
          h_nxt[3:0] = s_tmp;
          grp_nxt    = grp_r + 2'd1;
        end else if (out_free) begin
          h_nxt[3:0] = s_tmp;
          oh_lo_nxt  = s_tmp[0];
          oh_hi_nxt  = s_tmp[1];
          ov_nxt     = 1'b1;
          grp_nxt    = 2'd0;
          st_nxt     = BK_RUN;
        end
      end

      // three long end rounds, four steps a cycle
      BK_LEND: begin
        for (int k = 0; k < 4; k++) begin
          l_tmp = end_step(l_tmp, {grp_r, 2'(k)});
        end
        if (!(grp_r == 2'd2 && rnd_r == 2'd2)) begin
          h_nxt   = l_tmp;
          grp_nxt = (grp_r == 2'd2) ? 2'd0 : grp_r + 2'd1;
          if (grp_r == 2'd2) rnd_nxt = rnd_r + 2'd1;
        end else if (out_free) begin
          h_nxt     = l_tmp;
          oh_lo_nxt = l_tmp[0];
          oh_hi_nxt = l_tmp[1];
          ov_nxt    = 1'b1;
          grp_nxt   = 2'd0;
          rnd_nxt   = 2'd0;
          st_nxt    = BK_RUN;
        end
      end

      default: st_nxt = BK_RUN;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= BK_RUN;
      grp_r <= 2'd0;
      rnd_r <= 2'd0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      grp_r <= grp_nxt;
      rnd_r <= rnd_nxt;
      ov_r  <= ov_nxt;
    end
  end

  // hash state and payload
  always_ff @(posedge clk) begin
    short_r <= short_nxt;
    work_r  <= work_nxt;
    base_r  <= base_nxt;
    bw_r    <= bw_nxt;
    h_r     <= h_nxt;
    prev_r  <= prev_nxt;
    pw_r    <= pw_nxt;
    cur_r   <= cur_nxt;
    oh_lo_r <= oh_lo_nxt;
    oh_hi_r <= oh_hi_nxt;
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streamed 128-bit spooky hash. A directed table
// of short messages and special word encodings runs first, then random
// messages of short and long length under several seed settings. Every hash
// beat is checked against a behavioral hash computed inside the bench.
// ----------------------------------------------------------------------------
module testbench;
  import sh128_pkg::*;

  localparam logic [63:0] DEAD = 64'hdeadbeefdeadbeef;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_data_word;
  logic [3:0]  in_byte_count;
  logic        in_last_word;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_hash_low;
  logic [63:0] out_hash_high;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [63:0] cfg_data;

  spooky_hash128_stream uut (.*);

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // hash model state
  logic [63:0] seed_lo_m, seed_hi_m;
  logic [63:0] lane_st [12];
  logic [63:0] quad_st [4];
  logic [63:0] blk_data [12];
  logic [31:0] msg_len;
  int unsigned blk_pos;

  // expected hash words, oldest first
  logic [63:0] hash_lo_q [$];
  logic [63:0] hash_hi_q [$];
  int errors;

  // sender burst bookkeeping
  int burst_left;
  int words_sent;

  function automatic logic [63:0] rot64(logic [63:0] x, int k);
    if (k == 0) return x;
    return (x << k) | (x >> (64 - k));
  endfunction

  function automatic void load_seed_pattern();
    for (int i = 0; i < 12; i += 3) begin
      lane_st[i]     = seed_lo_m;
      lane_st[i + 1] = seed_hi_m;
      lane_st[i + 2] = DEAD;
    end
    quad_st[0] = seed_lo_m;
    quad_st[1] = seed_hi_m;
    quad_st[2] = DEAD;
    quad_st[3] = DEAD;
  endfunction

  // 96-byte block mix over the whole buffered block
  function automatic void lane_mix();
    int r [12] = '{11, 32, 43, 31, 17, 28, 39, 57, 55, 54, 22, 46};
    for (int i = 0; i < 12; i++) begin
      lane_st[i]             = lane_st[i] + blk_data[i];
      lane_st[(i + 2) % 12]  = lane_st[(i + 2) % 12] ^ lane_st[(i + 10) % 12];
      lane_st[(i + 11) % 12] = lane_st[(i + 11) % 12] ^ lane_st[i];
      lane_st[i]             = rot64(lane_st[i], r[i]);
      lane_st[(i + 11) % 12] = lane_st[(i + 11) % 12] + lane_st[(i + 1) % 12];
    end
  endfunction

  function automatic void quad_mix();
    int r [12] = '{50, 52, 30, 41, 54, 48, 38, 37, 62, 34, 5, 36};
    int x, y, z;
    for (int j = 0; j < 12; j++) begin
      x = (j + 2) % 4;
      y = (j + 3) % 4;
      z = j % 4;
      quad_st[x] = rot64(quad_st[x], r[j]);
      quad_st[x] = quad_st[x] + quad_st[y];
      quad_st[z] = quad_st[z] ^ quad_st[x];
    end
  endfunction

  // one accepted beat through the hash model
  function automatic void hash_word(logic [63:0] d, logic [3:0] c, logic l);
    int send_r [11] = '{15, 52, 26, 51, 28, 9, 47, 54, 32, 25, 63};
    int end_r [12] = '{44, 15, 34, 21, 38, 33, 10, 13, 38, 53, 42, 54};
    int unsigned nb, pos, q, rr, rem;
    logic [63:0] w;
    logic [32:0] sum;
    logic [31:0] newlen;
    logic [63:0] h [12];
    logic [63:0] s [4];
    logic [63:0] pad [12];
    logic done;
    int x, z, n1, n2, n11;
    nb = l ? ((c > 8) ? 8 : c) : 8;
    w = d;
    if (nb < 8) w = w & ((64'h1 << (8 * nb)) - 64'h1);
    if (msg_len == 0) load_seed_pattern();
    pos = (blk_pos > 11) ? 11 : blk_pos;
    q = pos % 4;
    blk_data[pos] = w;
    sum = {1'b0, msg_len} + nb;
    newlen = sum[32] ? 32'hffffffff : sum[31:0];
    // short path per 32-byte group
    if (q == 0) begin
      quad_st[2] = quad_st[2] + w;
    end else if (q == 1) begin
      quad_st[3] = quad_st[3] + w;
      if (nb == 8) quad_mix();
    end else if (q == 3 && nb == 8) begin
      quad_st[0] = quad_st[0] + blk_data[pos - 1];
      quad_st[1] = quad_st[1] + w;
    end
    done = (pos == 11 && nb == 8);
    if (done) begin
      lane_mix();
      blk_pos = 0;
    end else begin
      blk_pos = pos + 1;
    end
    if (!l) begin
      msg_len = newlen;
      return;
    end
    if (newlen < 192) begin
      // short message finish
      s = quad_st;
      rr = (q * 8 + nb) % 32;
      if (q == 2) begin
        s[2] = s[2] + w;
      end else if (q == 3 && nb < 8) begin
        s[2] = s[2] + blk_data[pos - 1];
        s[3] = s[3] + w;
      end
      if (rr >= 16) rr = rr - 16;
      if (rr == 0) begin
        s[2] = s[2] + DEAD;
        s[3] = s[3] + DEAD;
      end
      s[3] = s[3] + {newlen[7:0], 56'h0};
      for (int j = 0; j < 11; j++) begin
        x = (j + 2) % 4;
        z = (j + 3) % 4;
        s[z] = s[z] ^ s[x];
        s[x] = rot64(s[x], send_r[j]);
        s[z] = s[z] + s[x];
      end
      hash_lo_q.push_back(s[0]);
      hash_hi_q.push_back(s[1]);
    end else begin
      // long message finish: padded block and three end rounds
      rem = 0;
      for (int i = 0; i < 12; i++) pad[i] = 64'h0;
      if (!done) begin
        for (int i = 0; i <= pos; i++) pad[i] = blk_data[i];
        rem = pos * 8 + nb;
      end
      pad[11] = pad[11] | (64'(rem) << 56);
      for (int i = 0; i < 12; i++) h[i] = lane_st[i] + pad[i];
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 12; i++) begin
          n1 = (i + 1) % 12;
          n2 = (i + 2) % 12;
          n11 = (i + 11) % 12;
          h[n11] = h[n11] + h[n1];
          h[n2] = h[n2] ^ h[n11];
          h[n1] = rot64(h[n1], end_r[i]);
        end
      end
      hash_lo_q.push_back(h[0]);
      hash_hi_q.push_back(h[1]);
    end
    msg_len = 0;
    blk_pos = 0;
  endfunction

  // receiver stall pattern: quiet, random, or long holds
  int stall_cyc;
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1;
    case ((stall_cyc / 97) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      2: out_stall <= ((stall_cyc % 13) < 9);
      default: out_stall <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // hash beat checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (hash_lo_q.size() == 0) begin
        $display("%0t: unexpected hash beat %h %h", $time, out_hash_low, out_hash_high);
        errors++;
      end else begin
        if (out_hash_low !== hash_lo_q[0]) begin
          $display("%0t: hash_low expected %h actual %h", $time, hash_lo_q[0], out_hash_low);
          errors++;
        end
        if (out_hash_high !== hash_hi_q[0]) begin
          $display("%0t: hash_high expected %h actual %h", $time, hash_hi_q[0],
                   out_hash_high);
          errors++;
        end
        void'(hash_lo_q.pop_front());
        void'(hash_hi_q.pop_front());
      end
    end
  end

  // one input beat, with burst gaps in front of it
  task automatic send_word(input logic [63:0] d, input logic [3:0] c, input logic l);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data_word <= d;
    in_byte_count <= c;
    in_last_word <= l;
    do @(posedge clk); while (in_stall);
    hash_word(d, c, l);
    words_sent++;
  endtask

  // idle the block, then load both seeds
  task automatic set_seeds(input logic [63:0] lo, input logic [63:0] hi);
    in_valid <= 1'b0;
    wait (hash_lo_q.size() == 0);
    repeat (30) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SEED_LOW;
    cfg_data <= lo;
    @(posedge clk);
    seed_lo_m = lo;
    cfg_index <= CFG_SEED_HIGH;
    cfg_data <= hi;
    @(posedge clk);
    seed_hi_m = hi;
    cfg_wr_en <= 1'b0;
  endtask

  // random message: mostly well formed, some odd counts
  task automatic send_message();
    int n;
    logic [3:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: n = $urandom_range(1, 8);
      4, 5: n = $urandom_range(9, 30);
      6: n = $urandom_range(23, 25);
      7, 8: n = $urandom_range(31, 60);
      default: n = $urandom_range(1, 3);
    endcase
    for (int i = 0; i < n - 1; i++) begin
      c = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
      send_word({$urandom, $urandom}, c, 1'b0);
    end
    c = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    send_word({$urandom, $urandom}, c, 1'b1);
  endtask

  typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
  } beat_row_t;

  // directed messages: empty, extremes, masking, odd counts, pad boundaries
  beat_row_t dir_rows [] = '{
    '{64'h0, 4'd0, 1'b1},
    '{64'hffffffffffffffff, 4'd8, 1'b1},
    '{64'hffffffffffffffff, 4'd3, 1'b1},
    '{64'h0123456789abcdef, 4'd15, 1'b1},
    '{64'hffffffffffffffff, 4'd9, 1'b1},
    '{64'h8000000000000001, 4'd2, 1'b0},
    '{64'hfedcba9876543210, 4'd5, 1'b1},
    '{64'h1111111111111111, 4'd8, 1'b0},
    '{64'h2222222222222222, 4'd8, 1'b1},
    '{64'ha5a5a5a5a5a5a5a5, 4'd8, 1'b0},
    '{64'h5a5a5a5a5a5a5a5a, 4'd8, 1'b0},
    '{64'h0f0f0f0f0f0f0f0f, 4'd8, 1'b0},
    '{64'hf0f0f0f0f0f0f0f0, 4'd8, 1'b1},
    '{64'h0, 4'd8, 1'b0},
    '{64'hffffffffffffffff, 4'd8, 1'b0},
    '{64'hffffffffffffffff, 4'd4, 1'b1},
    '{64'h0, 4'd0, 1'b0},
    '{64'h7fffffffffffffff, 4'd8, 1'b0},
    '{64'h1, 4'd8, 1'b0},
    '{64'hffffffffffffffff, 4'd7, 1'b1},
    '{64'hffffffffffffffff, 4'd8, 1'b0},
    '{64'hffffffffffffffff, 4'd0, 1'b1}
  };

  // stimulus
  initial begin
    errors = 0;
    burst_left = 0;
    words_sent = 0;
    stall_cyc = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_word = 64'h0;
    in_byte_count = 4'd0;
    in_last_word = 1'b0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_SEED_LOW;
    cfg_data = 64'h0;
    seed_lo_m = 64'h0;
    seed_hi_m = 64'h0;
    msg_len = 0;
    blk_pos = 0;
    for (int i = 0; i < 12; i++) blk_data[i] = 64'h0;
    load_seed_pattern();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_word(dir_rows[i].data, dir_rows[i].count, dir_rows[i].last);

    // random messages across seed settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_seeds(64'hffffffffffffffff, 64'hffffffffffffffff);
        1: set_seeds(64'h0, 64'hffffffffffffffff);
        2: set_seeds(64'hffffffffffffffff, 64'h0);
        3: set_seeds(64'h0, 64'h0);
        default: set_seeds({$urandom, $urandom}, {$urandom, $urandom});
      endcase
      while (words_sent < (ph + 1) * 180) begin
        send_message();
      end
    end

    in_valid <= 1'b0;
    wait (hash_lo_q.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
rtl/sh128_pkg.sv
rtl/sh128_front.sv
rtl/sh128_queue.sv
rtl/sh128_back.sv
rtl/spooky_hash128_stream.sv
test/testbench.sv
